>>> hdl/mar_pkg.sv
`timescale 1ns / 1ps
package mar_pkg;

    // turn word and fixed-point formats of the sine path
    localparam int unsigned TURN_W  = 32;
    localparam int unsigned Q_FRAC  = 30;
    localparam int unsigned MAG_W   = 31;          // Q30 magnitudes up to and including 1.0
    localparam int unsigned MAG_PW  = 2 * MAG_W;
    localparam int unsigned SQ_W    = 32;          // x squared, below 2.5 in Q30
    localparam int unsigned SQ_PW   = 2 * SQ_W;
    localparam int unsigned COEF_W  = 32;          // signed sine or cosine coefficient

    localparam logic [MAG_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [MAG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    // Horner divisors of the sine series, applied in this order
    localparam int unsigned N_HORNER = 6;
    localparam int unsigned HORNER_DIV [N_HORNER] = '{156, 110, 72, 42, 20, 6};

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // one sine or cosine evaluation in flight
    typedef struct packed {
        logic [MAG_W-1:0] x;
        logic [SQ_W-1:0]  x2;
        logic [MAG_W-1:0] p;
    } t_lane;

endpackage

>>> hdl/mar_prep.sv
`timescale 1ns / 1ps
module mar_prep #(
    parameter int unsigned ANGLE_WIDTH = 16,
    parameter int unsigned SIDE_W      = 130
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [ANGLE_WIDTH-1:0]   i_turn_angle,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output mar_pkg::t_lane [1:0]     o_lane,
    output logic [SIDE_W+1:0]        o_side
);
    import mar_pkg::*;

    logic [2:0]          r_v;
    logic [2:0]          en;
    logic [TURN_W-1:0]   turn;
    logic [1:0]          quad [2];
    logic [MAG_W-1:0]    rem;
    logic [MAG_W-1:0]    n_arg [2];
    logic [MAG_W-1:0]    n_x [2];
    t_lane [1:0]         n_lane;

    logic [MAG_W-1:0]    r_s1_arg [2];
    logic [SIDE_W+1:0]   r_s1_side;
    logic [MAG_W-1:0]    r_s2_x [2];
    logic [SIDE_W+1:0]   r_s2_side;
    t_lane [1:0]         r_s3_lane;
    logic [SIDE_W+1:0]   r_s3_side;

    always_comb begin
        en[2] = !r_v[2] || i_ready;
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end

    assign o_ready = en[0];
    assign o_valid = r_v[2];
    assign o_lane  = r_s3_lane;
    assign o_side  = r_s3_side;

    // lane 0 is the sine, lane 1 the cosine (a quarter turn ahead)
    always_comb begin
        turn    = TURN_W'(i_turn_angle) << (TURN_W - ANGLE_WIDTH);
        quad[0] = turn[TURN_W-1 -: 2];
        quad[1] = quad[0] + 2'd1;
        rem     = {1'b0, turn[Q_FRAC-1:0]};
        for (int k = 0; k < 2; k++) begin
            // mirror the odd quadrants onto the rising quarter wave
            n_arg[k] = quad[k][0] ? Q30_ONE - rem : rem;
            n_x[k]   = MAG_W'((MAG_PW'(r_s1_arg[k]) * MAG_PW'(HALF_PI_Q30)) >> Q_FRAC);
            n_lane[k].x  = r_s2_x[k];
            n_lane[k].x2 = SQ_W'((SQ_PW'(r_s2_x[k]) * SQ_PW'(r_s2_x[k])) >> Q_FRAC);
            n_lane[k].p  = Q30_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            if (en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_arg  <= n_arg;
            r_s1_side <= {quad[1][1], quad[0][1], i_side};
        end
        if (en[1]) begin
            r_s2_x    <= n_x;
            r_s2_side <= r_s1_side;
        end
        if (en[2]) begin
            r_s3_lane <= n_lane;
            r_s3_side <= r_s2_side;
        end
    end

    a_arg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_s1_arg[0] <= Q30_ONE) && (r_s1_arg[1] <= Q30_ONE))
        else $error("quarter-wave argument above one");

endmodule

>>> hdl/mar_cell.sv
`timescale 1ns / 1ps
module mar_cell #(
    parameter int unsigned DIV    = 6,
    parameter int unsigned SIDE_W = 132
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mar_pkg::t_lane [1:0] i_lane,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mar_pkg::t_lane [1:0] o_lane,
    output logic [SIDE_W-1:0]    o_side
);
    import mar_pkg::*;

    // exact floor division of a 32-bit word by DIV through a rounded-up reciprocal
    localparam int unsigned SHIFT   = SQ_W + $clog2(DIV);
    localparam int unsigned RMUL_W  = SQ_PW + 1;
    localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [SQ_W:0] RECIP = RECIP64[SQ_W:0];

    logic               r_va;
    logic               r_vb;
    logic               en_a;
    logic               en_b;
    logic [SQ_W-1:0]    n_prod [2];
    logic [RMUL_W-1:0]  recip_mul [2];
    logic [SQ_W-1:0]    quot [2];
    t_lane [1:0]        n_lane;

    logic [MAG_W-1:0]   r_a_x [2];
    logic [SQ_W-1:0]    r_a_x2 [2];
    logic [SQ_W-1:0]    r_a_prod [2];
    logic [SIDE_W-1:0]  r_a_side;
    t_lane [1:0]        r_b_lane;
    logic [SIDE_W-1:0]  r_b_side;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_lane  = r_b_lane;
    assign o_side  = r_b_side;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_prod[k]    = SQ_W'((SQ_PW'(i_lane[k].x2) * SQ_PW'(i_lane[k].p)) >> Q_FRAC);
            recip_mul[k] = RMUL_W'(r_a_prod[k]) * RMUL_W'(RECIP);
            quot[k]      = SQ_W'(recip_mul[k] >> SHIFT);
            n_lane[k].x  = r_a_x[k];
            n_lane[k].x2 = r_a_x2[k];
            n_lane[k].p  = Q30_ONE - MAG_W'(quot[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            for (int k = 0; k < 2; k++) begin
                r_a_x[k]    <= i_lane[k].x;
                r_a_x2[k]   <= i_lane[k].x2;
                r_a_prod[k] <= n_prod[k];
            end
            r_a_side <= i_side;
        end
        if (en_b) begin
            r_b_lane <= n_lane;
            r_b_side <= r_a_side;
        end
    end

    a_p_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (r_b_lane[0].p <= Q30_ONE) && (r_b_lane[1].p <= Q30_ONE))
        else $error("Horner term above one");

endmodule

>>> hdl/mar_rot.sv
`timescale 1ns / 1ps
module mar_rot #(
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  mar_pkg::t_lane [1:0]          i_lane,
    input  logic [4*ELEM_WIDTH+3:0]       i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ELEM_WIDTH-1:0]  o_a,
    output logic signed [ELEM_WIDTH-1:0]  o_b,
    output logic signed [ELEM_WIDTH-1:0]  o_c,
    output logic signed [ELEM_WIDTH-1:0]  o_d
);
    import mar_pkg::*;

    localparam int unsigned HW    = ELEM_WIDTH / 2;
    localparam int unsigned HIW   = ELEM_WIDTH - HW;
    localparam int unsigned HI_PW = HIW + COEF_W;
    localparam int unsigned LO_PW = HW + 1 + COEF_W;
    localparam int unsigned ACC_W = ELEM_WIDTH + COEF_W + 1;
    localparam int unsigned SH_W  = ACC_W - Q_FRAC;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (Q_FRAC - 1);
    localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic [4:0] r_v;
    logic [4:0] en;

    // stage 1: coefficients
    t_axis                        side_op;
    logic [1:0]                   side_neg;
    logic                         sin_neg;
    logic [MAG_W-1:0]             mag [2];
    logic signed [COEF_W-1:0]     pos_s;
    logic signed [COEF_W-1:0]     pos_c;
    logic signed [COEF_W-1:0]     n_cs;
    logic signed [COEF_W-1:0]     n_ss;
    logic signed [COEF_W-1:0]     n_ns;
    logic signed [COEF_W-1:0]     r_s1_cs;
    logic signed [COEF_W-1:0]     r_s1_ss;
    logic signed [COEF_W-1:0]     r_s1_ns;
    t_axis                        r_s1_op;
    logic signed [ELEM_WIDTH-1:0] r_s1_row [4];

    // stage 2: split partial products
    logic signed [ELEM_WIDTH-1:0] mul_e [4];
    logic signed [COEF_W-1:0]     mul_k [4];
    logic signed [HIW-1:0]        e_hi [4];
    logic signed [HW:0]           e_lo [4];
    logic signed [HI_PW-1:0]      n_hi [4];
    logic signed [LO_PW-1:0]      n_lo [4];
    logic signed [HI_PW-1:0]      r_s2_hi [4];
    logic signed [LO_PW-1:0]      r_s2_lo [4];
    t_axis                        r_s2_op;
    logic signed [ELEM_WIDTH-1:0] r_s2_row [4];

    // stage 3: full products
    logic signed [ACC_W-1:0]      n_term [4];
    logic signed [ACC_W-1:0]      r_s3_term [4];
    t_axis                        r_s3_op;
    logic signed [ELEM_WIDTH-1:0] r_s3_row [4];

    // stage 4: pair sums with rounding bias
    logic signed [ACC_W-1:0]      n_acc [2];
    logic signed [ACC_W-1:0]      r_s4_acc [2];
    t_axis                        r_s4_op;
    logic signed [ELEM_WIDTH-1:0] r_s4_row [4];

    // stage 5: saturate and place
    logic [SH_W-1:0]              shifted [2];
    logic [3:0]                   top_bits [2];
    logic signed [ELEM_WIDTH-1:0] res [2];
    logic signed [ELEM_WIDTH-1:0] n_out [4];
    logic signed [ELEM_WIDTH-1:0] r_out_row [4];

    always_comb begin
        en[4] = !r_v[4] || i_ready;
        for (int k = 3; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[4];
    assign o_a     = r_out_row[0];
    assign o_b     = r_out_row[1];
    assign o_c     = r_out_row[2];
    assign o_d     = r_out_row[3];

    always_comb begin
        side_op  = t_axis'(i_side[4*ELEM_WIDTH +: 2]);
        side_neg = i_side[4*ELEM_WIDTH+2 +: 2];
        for (int k = 0; k < 2; k++) begin
            mag[k] = MAG_W'((MAG_PW'(i_lane[k].x) * MAG_PW'(i_lane[k].p)) >> Q_FRAC);
        end
        pos_s = $signed({1'b0, mag[0]});
        pos_c = $signed({1'b0, mag[1]});
        // the y axis turns the other way round
        sin_neg = side_neg[0] ^ (side_op == AXIS_Y);
        n_ss = sin_neg ? -pos_s : pos_s;
        n_ns = sin_neg ? pos_s : -pos_s;
        n_cs = side_neg[1] ? -pos_c : pos_c;
    end

    // p' = p*c + q*s ; q' = -p*s + q*c
    always_comb begin
        case (r_s1_op)
            AXIS_X: begin
                mul_e[0] = r_s1_row[1];
                mul_e[1] = r_s1_row[2];
            end
            AXIS_Y: begin
                mul_e[0] = r_s1_row[0];
                mul_e[1] = r_s1_row[2];
            end
            default: begin
                mul_e[0] = r_s1_row[0];
                mul_e[1] = r_s1_row[1];
            end
        endcase
        mul_e[2] = mul_e[0];
        mul_e[3] = mul_e[1];
        mul_k[0] = r_s1_cs;
        mul_k[1] = r_s1_ss;
        mul_k[2] = r_s1_ns;
        mul_k[3] = r_s1_cs;
        for (int k = 0; k < 4; k++) begin
            e_hi[k] = mul_e[k][ELEM_WIDTH-1:HW];
            e_lo[k] = {1'b0, mul_e[k][HW-1:0]};
            n_hi[k] = e_hi[k] * mul_k[k];
            n_lo[k] = e_lo[k] * mul_k[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_term[k] = (ACC_W'(r_s2_hi[k]) <<< HW) + ACC_W'(r_s2_lo[k]);
        end
        n_acc[0] = r_s3_term[0] + r_s3_term[1] + ROUND_HALF;
        n_acc[1] = r_s3_term[2] + r_s3_term[3] + ROUND_HALF;
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            shifted[k]  = r_s4_acc[k][ACC_W-1:Q_FRAC];
            top_bits[k] = shifted[k][SH_W-1:ELEM_WIDTH-1];
            if (&top_bits[k] || ~|top_bits[k]) begin
                res[k] = shifted[k][ELEM_WIDTH-1:0];
            end else begin
                res[k] = shifted[k][SH_W-1] ? ELEM_MIN : ELEM_MAX;
            end
        end
        n_out = r_s4_row;
        case (r_s4_op)
            AXIS_X: begin
                n_out[1] = res[0];
                n_out[2] = res[1];
            end
            AXIS_Y: begin
                n_out[0] = res[0];
                n_out[2] = res[1];
            end
            AXIS_Z: begin
                n_out[0] = res[0];
                n_out[1] = res[1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_cs     <= n_cs;
            r_s1_ss     <= n_ss;
            r_s1_ns     <= n_ns;
            r_s1_op     <= side_op;
            r_s1_row[0] <= i_side[3*ELEM_WIDTH +: ELEM_WIDTH];
            r_s1_row[1] <= i_side[2*ELEM_WIDTH +: ELEM_WIDTH];
            r_s1_row[2] <= i_side[ELEM_WIDTH +: ELEM_WIDTH];
            r_s1_row[3] <= i_side[0 +: ELEM_WIDTH];
        end
        if (en[1]) begin
            r_s2_hi  <= n_hi;
            r_s2_lo  <= n_lo;
            r_s2_op  <= r_s1_op;
            r_s2_row <= r_s1_row;
        end
        if (en[2]) begin
            r_s3_term <= n_term;
            r_s3_op   <= r_s2_op;
            r_s3_row  <= r_s2_row;
        end
        if (en[3]) begin
            r_s4_acc <= n_acc;
            r_s4_op  <= r_s3_op;
            r_s4_row <= r_s3_row;
        end
        if (en[4]) begin
            r_out_row <= n_out;
        end
    end

    a_row_a_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en[4] && r_v[3] && r_s4_op != AXIS_Y && r_s4_op != AXIS_Z
        |=> r_out_row[0] == $past(r_s4_row[0]))
        else $error("row a changed on an axis that keeps it");

    a_row_c_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en[4] && r_v[3] && (r_s4_op == AXIS_Z || r_s4_op == AXIS_NONE)
        |=> r_out_row[2] == $past(r_s4_row[2]))
        else $error("row c changed on an axis that keeps it");

endmodule

>>> hdl/matrix_axis_rotation.sv
// Throughput: one column word per cycle unless i_stall holds the output, through a
// 20-stage pipeline: 3 angle stages, six two-stage Horner cells shared by the
// sine and cosine lanes, 5 product stages.
// Every stage has its own valid bit, so bubbles soak up a downstream stall.
// Reset (i_rst_n, synchronous, active low) clears only the valid bits.
`timescale 1ns / 1ps
module matrix_axis_rotation #(
    parameter int unsigned ELEM_WIDTH  = 32,
    parameter int unsigned ANGLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_op,
    input  logic [ANGLE_WIDTH-1:0]        i_turn_angle,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_b,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_c,
    input  logic signed [ELEM_WIDTH-1:0]  i_elem_d,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ELEM_WIDTH-1:0]  o_out_a,
    output logic signed [ELEM_WIDTH-1:0]  o_out_b,
    output logic signed [ELEM_WIDTH-1:0]  o_out_c,
    output logic signed [ELEM_WIDTH-1:0]  o_out_d
);
    import mar_pkg::*;

    localparam int unsigned COL_W  = 4 * ELEM_WIDTH + 2;
    localparam int unsigned SIDE_W = COL_W + 2;

    logic               prep_ready;
    logic               chain_valid [N_HORNER+1];
    logic               chain_ready [N_HORNER+1];
    t_lane [1:0]        chain_lane [N_HORNER+1];
    logic [SIDE_W-1:0]  chain_side [N_HORNER+1];

    assign o_stall = !prep_ready;

    mar_prep #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .SIDE_W      (COL_W)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (prep_ready),
        .i_turn_angle (i_turn_angle),
        .i_side       ({i_op, i_elem_a, i_elem_b, i_elem_c, i_elem_d}),
        .o_valid      (chain_valid[0]),
        .i_ready      (chain_ready[0]),
        .o_lane       (chain_lane[0]),
        .o_side       (chain_side[0])
    );

    for (genvar g = 0; g < N_HORNER; g++) begin : g_cell
        mar_cell #(
            .DIV    (HORNER_DIV[g]),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_lane  (chain_lane[g]),
            .i_side  (chain_side[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_lane  (chain_lane[g+1]),
            .o_side  (chain_side[g+1])
        );
    end

    mar_rot #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[N_HORNER]),
        .o_ready (chain_ready[N_HORNER]),
        .i_lane  (chain_lane[N_HORNER]),
        .i_side  (chain_side[N_HORNER]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_a     (o_out_a),
        .o_b     (o_out_b),
        .o_c     (o_out_c),
        .o_d     (o_out_d)
    );

    // an empty output register frees every stage behind it
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

endmodule

>>> test/tb_matrix_axis_rotation.sv
`timescale 1ns / 1ps
module tb_matrix_axis_rotation;
    import mar_pkg::*;

    localparam int unsigned ELEM_W     = 32;
    localparam int unsigned ANG_W      = 16;
    localparam int unsigned QUIET_MAX  = 5000;
    localparam int unsigned DRAIN_WAIT = 40;
    localparam int unsigned RAND_WORDS = 1900;

    localparam logic [63:0] ONE_Q30    = 64'h4000_0000;
    localparam logic [63:0] HALF_PI_30 = 64'd1686629713;
    localparam int unsigned SERIES_DIV [6] = '{156, 110, 72, 42, 20, 6};

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
    localparam logic signed [ELEM_W-1:0] FX_ONE   = 32'sh0001_0000;

    typedef struct {
        t_axis                    op;
        logic [ANG_W-1:0]         angle;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic signed [ELEM_W-1:0] c;
        logic signed [ELEM_W-1:0] d;
    } t_column;

    typedef struct {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic signed [ELEM_W-1:0] c;
        logic signed [ELEM_W-1:0] d;
    } t_rotated;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_op         = 2'd0;
    logic [ANG_W-1:0]         i_turn_angle = '0;
    logic signed [ELEM_W-1:0] i_elem_a     = '0;
    logic signed [ELEM_W-1:0] i_elem_b     = '0;
    logic signed [ELEM_W-1:0] i_elem_c     = '0;
    logic signed [ELEM_W-1:0] i_elem_d     = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic signed [ELEM_W-1:0] o_out_a;
    logic signed [ELEM_W-1:0] o_out_b;
    logic signed [ELEM_W-1:0] o_out_c;
    logic signed [ELEM_W-1:0] o_out_d;

    t_rotated    expected_cols[$];
    t_rotated    want;
    int unsigned mismatches  = 0;
    int unsigned quiet_count = 0;
    int unsigned hold_cnt    = 0;
    int unsigned stall_len;
    bit          gaps_on     = 1'b0;
    bit          stall_en    = 1'b0;

    matrix_axis_rotation #(
        .ELEM_WIDTH  (ELEM_W),
        .ANGLE_WIDTH (ANG_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_turn_angle (i_turn_angle),
        .i_elem_a     (i_elem_a),
        .i_elem_b     (i_elem_b),
        .i_elem_c     (i_elem_c),
        .i_elem_d     (i_elem_d),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_a      (o_out_a),
        .o_out_b      (o_out_b),
        .o_out_c      (o_out_c),
        .o_out_d      (o_out_d)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // sine of the first quadrant, r in Q30 turns of a quarter wave
    function automatic logic [63:0] quarter_wave(logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        x  = (r * HALF_PI_30) >> 30;
        x2 = (x * x) >> 30;
        p  = ONE_Q30;
        for (int k = 0; k < 6; k++) begin
            p = ONE_Q30 - (((x2 * p) >> 30) / 64'(SERIES_DIV[k]));
        end
        return (x * p) >> 30;
    endfunction

    function automatic logic signed [31:0] turn_sin(logic [31:0] t);
        logic [63:0] mag;
        logic [63:0] r;
        r   = {34'd0, t[29:0]};
        mag = t[30] ? quarter_wave(ONE_Q30 - r) : quarter_wave(r);
        return t[31] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    // round half up from Q30 and clamp to the element range
    function automatic logic signed [ELEM_W-1:0] round_sat(logic signed [95:0] acc);
        logic signed [95:0] q;
        q = (acc + 96'sd536870912) >>> 30;
        if (q > 96'sd2147483647)
            return ELEM_MAX;
        if (q < -96'sd2147483648)
            return ELEM_MIN;
        return q[ELEM_W-1:0];
    endfunction

    // p' = p*cs + q*sn, q' = -p*sn + q*cs
    function automatic void spin_pair(
        input  logic signed [ELEM_W-1:0] p,
        input  logic signed [ELEM_W-1:0] q,
        input  logic signed [31:0]       cs,
        input  logic signed [31:0]       sn,
        output logic signed [ELEM_W-1:0] po,
        output logic signed [ELEM_W-1:0] qo
    );
        logic signed [95:0] pw;
        logic signed [95:0] qw;
        logic signed [95:0] cw;
        logic signed [95:0] sw;
        pw = p;
        qw = q;
        cw = cs;
        sw = sn;
        po = round_sat(pw * cw + qw * sw);
        qo = round_sat(qw * cw - pw * sw);
    endfunction

    function automatic t_rotated rotate_column(t_column col);
        logic [31:0]        turn;
        logic signed [31:0] s;
        logic signed [31:0] c;
        t_rotated           res;
        turn  = {col.angle, 16'h0000};
        s     = turn_sin(turn);
        c     = turn_sin(turn + 32'h4000_0000);
        res.a = col.a;
        res.b = col.b;
        res.c = col.c;
        res.d = col.d;
        case (col.op)
            AXIS_X: spin_pair(col.b, col.c, c, s, res.b, res.c);
            AXIS_Y: spin_pair(col.a, col.c, c, -s, res.a, res.c);
            AXIS_Z: spin_pair(col.a, col.b, c, s, res.a, res.b);
            default: ;
        endcase
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(bit enable);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enable || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return $signed(32'($urandom_range(0, 32'h7_ffff))) - 32'sh4_0000;
            8: return ($urandom_range(0, 1) != 0) ? ELEM_MAX : ELEM_MIN;
            default: return $signed(32'($urandom_range(0, 2))) - 32'sd1;
        endcase
    endfunction

    task automatic send_column(t_column col);
        int unsigned gap;
        gap = pick_gap(gaps_on);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= col.op;
        i_turn_angle <= col.angle;
        i_elem_a     <= col.a;
        i_elem_b     <= col.b;
        i_elem_c     <= col.c;
        i_elem_d     <= col.d;
        // hold the word until it is taken
        do @(posedge i_clk); while (o_stall);
        expected_cols.push_back(rotate_column(col));
    endtask

    task automatic send_simple(t_axis op, logic [ANG_W-1:0] angle,
                               logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                               logic signed [ELEM_W-1:0] c, logic signed [ELEM_W-1:0] d);
        t_column col;
        col.op    = op;
        col.angle = angle;
        col.a     = a;
        col.b     = b;
        col.c     = c;
        col.d     = d;
        send_column(col);
    endtask

    task automatic test_axes();
        t_axis op;
        op = AXIS_X;
        // thirty degrees on every axis, plus the unused selector
        for (int k = 0; k < 4; k++) begin
            send_simple(t_axis'(k), 16'h1555, FX_ONE, 2 * FX_ONE, -3 * FX_ONE, 32'sh1234_5678);
        end
        send_simple(op, 16'h2000, ELEM_MIN, ELEM_MAX, FX_ONE, ELEM_MIN);
    endtask

    task automatic test_angles();
        logic [ANG_W-1:0] angles [8] = '{16'h0000, 16'h0001, 16'h2000, 16'h4000,
                                         16'h8000, 16'hc000, 16'hffff, 16'h7fff};
        foreach (angles[k]) begin
            send_simple(AXIS_Z, angles[k], FX_ONE, FX_ONE / 2, 32'sh0fff_ffff, -FX_ONE);
        end
    endtask

    task automatic test_saturation();
        send_simple(AXIS_Z, 16'h2000, ELEM_MAX, ELEM_MAX, 0, ELEM_MAX);
        send_simple(AXIS_Z, 16'h2000, ELEM_MIN, ELEM_MIN, ELEM_MAX, 0);
        send_simple(AXIS_X, 16'he000, 0, ELEM_MIN, ELEM_MAX, -1);
        send_simple(AXIS_Y, 16'h2000, ELEM_MAX, -1, ELEM_MIN, 1);
        // negating the most negative element overflows
        send_simple(AXIS_X, 16'h8000, 1, ELEM_MIN, ELEM_MIN, ELEM_MAX);
        send_simple(AXIS_Y, 16'h6000, ELEM_MIN, 0, ELEM_MAX, ELEM_MIN);
        send_simple(AXIS_NONE, 16'hffff, ELEM_MAX, ELEM_MIN, -1, 0);
    endtask

    task automatic test_random();
        t_column col;
        int unsigned r;
        for (int n = 0; n < RAND_WORDS; n++) begin
            // switch idling on and off in blocks of words
            if (n % 100 == 0) begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_en = ($urandom_range(0, 3) != 0);
            end
            r         = $urandom_range(0, 9);
            col.op    = (r == 9) ? AXIS_NONE : t_axis'(r % 3);
            col.angle = ANG_W'($urandom);
            col.a     = pick_elem();
            col.b     = pick_elem();
            col.c     = pick_elem();
            col.d     = pick_elem();
            send_column(col);
        end
    endtask

    function automatic void check_elem(string name, logic signed [ELEM_W-1:0] exp_val,
                                       logic signed [ELEM_W-1:0] got);
        if (got !== exp_val) begin
            $error("%s: expected %h, got %h", name, exp_val, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cols.size() == 0) begin
                $error("column word with nothing pending: %h %h %h %h",
                       o_out_a, o_out_b, o_out_c, o_out_d);
                mismatches++;
            end else begin
                want = expected_cols.pop_front();
                check_elem("out_a", want.a, o_out_a);
                check_elem("out_b", want.b, o_out_b);
                check_elem("out_c", want.c, o_out_c);
                check_elem("out_d", want.d, o_out_d);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (i_stall) begin
            i_stall  <= 1'b0;
            hold_cnt <= $urandom_range(0, 12);
        end else begin
            stall_len = pick_gap(stall_en);
            if (stall_len != 0) begin
                i_stall  <= 1'b1;
                hold_cnt <= stall_len - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (i_rst_n && o_valid && !i_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        gaps_on  = 1'b1;
        stall_en = 1'b1;
        test_axes();
        test_angles();
        test_saturation();
        test_random();
        i_valid <= 1'b0;
        while (expected_cols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/mar_pkg.sv
hdl/mar_prep.sv
hdl/mar_cell.sv
hdl/mar_rot.sv
hdl/matrix_axis_rotation.sv
test/tb_matrix_axis_rotation.sv
